/* rtl/ohlc_pkg.sv */
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared constants and types for the OHLC bar aggregator.
// ----------------------------------------------------------------------------
package ohlc_pkg;

  // Group size register and fill counter widths
  localparam int unsigned GROUP_W   = 7;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned GROUP_MAX = 64;

  // Common group settings
  localparam logic [GROUP_W-1:0] GROUP_DAILY   = 7'd1;
  localparam logic [GROUP_W-1:0] GROUP_WEEKLY  = 7'd5;
  localparam logic [GROUP_W-1:0] GROUP_MONTHLY = 7'd20;

  // Control flags the merge stage hands back to the top level
  typedef struct packed {
    logic emit;   // this candle closes a bar
    logic last;   // the bar also ends the series
  } merge_ctl_t;

endpackage

/* rtl/ohlc_merge.sv */
// ----------------------------------------------------------------------------
// ohlc_merge
// Merges one candle into the held bar and the series extremes (combinational).
// ----------------------------------------------------------------------------
module ohlc_merge #(
  parameter int unsigned PRICE_BITS = 32
) (
  // candle
  input  logic [PRICE_BITS-1:0]         price_open_i,
  input  logic [PRICE_BITS-1:0]         price_high_i,
  input  logic [PRICE_BITS-1:0]         price_low_i,
  input  logic                          series_end_i,
  // configuration
  input  logic [ohlc_pkg::GROUP_W-1:0]  group_size_i,
  // current state
  input  logic [ohlc_pkg::COUNT_W-1:0]  fill_count_i,
  input  logic [PRICE_BITS-1:0]         held_open_i,
  input  logic [PRICE_BITS-1:0]         held_high_i,
  input  logic [PRICE_BITS-1:0]         held_low_i,
  input  logic [PRICE_BITS-1:0]         series_max_i,
  input  logic [PRICE_BITS-1:0]         series_min_i,
  input  logic                          series_started_i,
  // merged values (bar contents before any clearing)
  output logic [ohlc_pkg::COUNT_W-1:0]  fill_count_o,
  output logic [PRICE_BITS-1:0]         held_open_o,
  output logic [PRICE_BITS-1:0]         held_high_o,
  output logic [PRICE_BITS-1:0]         held_low_o,
  output logic [PRICE_BITS-1:0]         series_max_o,
  output logic [PRICE_BITS-1:0]         series_min_o,
  output ohlc_pkg::merge_ctl_t          ctl_o
);

  logic [ohlc_pkg::GROUP_W-1:0] eff_group;
  logic [ohlc_pkg::GROUP_W-1:0] count;
  logic                         first;

  // zero acts as one, anything past the max saturates
  always_comb begin
    if (group_size_i == '0) begin
      eff_group = ohlc_pkg::GROUP_W'(1);
    end else if (group_size_i > ohlc_pkg::GROUP_W'(ohlc_pkg::GROUP_MAX)) begin
      eff_group = ohlc_pkg::GROUP_W'(ohlc_pkg::GROUP_MAX);
    end else begin
      eff_group = group_size_i;
    end
  end

  assign first = (fill_count_i == '0);
  assign count = {1'b0, fill_count_i} + ohlc_pkg::GROUP_W'(1);

  assign series_max_o = (price_high_i > series_max_i) ? price_high_i : series_max_i;
  assign series_min_o = (!series_started_i || price_low_i < series_min_i) ?
                        price_low_i : series_min_i;

  assign held_open_o = first ? price_open_i : held_open_i;
  assign held_high_o = (first || price_high_i > held_high_i) ? price_high_i : held_high_i;
  assign held_low_o  = (first || price_low_i < held_low_i) ? price_low_i : held_low_i;

  assign ctl_o.last   = series_end_i;
  assign ctl_o.emit   = series_end_i || (count >= eff_group);
  // only kept when no bar is emitted, so count stays below the group max
  assign fill_count_o = count[ohlc_pkg::COUNT_W-1:0];

endmodule

/* rtl/ohlc_bar_aggregator_unit.sv */
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator_unit
// Resamples a stream of OHLC candles into bars of a configurable size.
// ----------------------------------------------------------------------------
// Candles (unsigned Q16.16 open/high/low/close plus a series_end mark) enter
// one transaction per cycle and are grouped into bars of group_size candles
// (1 daily, 5 weekly, 20 monthly; 0 acts as 1, above 64 saturates to 64).
// A bar carries the first open, the max high, the min low and the last close,
// and is emitted on the candle that fills the group or on a candle marked
// series_end, so a partial group closes at the end of a series. Each bar also
// carries the running series high (starting from zero) and low (starting from
// the first low); both clear after the final bar. Throughput is one candle
// per cycle while no bar is held back: a candle is captured in an input
// register, merged into the held bar by combinational compares, and a bar
// lands in the result register. The only back pressure is a bar that
// cannot leave because the result register is still occupied and stalled;
// candles that close no bar keep flowing. group_size must only be written
// while the unit is idle.
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator_unit #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_wr_en_i,
  input  logic [ohlc_pkg::GROUP_W-1:0]  cfg_wr_data_i,
  // candle channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [PRICE_BITS-1:0]         price_open_i,
  input  logic [PRICE_BITS-1:0]         price_high_i,
  input  logic [PRICE_BITS-1:0]         price_low_i,
  input  logic [PRICE_BITS-1:0]         price_close_i,
  input  logic                          series_end_i,
  // bar channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [PRICE_BITS-1:0]         bar_open_o,
  output logic [PRICE_BITS-1:0]         bar_high_o,
  output logic [PRICE_BITS-1:0]         bar_low_o,
  output logic [PRICE_BITS-1:0]         bar_close_o,
  output logic [PRICE_BITS-1:0]         overall_high_o,
  output logic [PRICE_BITS-1:0]         overall_low_o,
  output logic                          final_bar_o
);

  // configuration register
  logic [ohlc_pkg::GROUP_W-1:0] group_size_q;

  // input register
  logic                  in_vld_q;
  logic [PRICE_BITS-1:0] in_open_q, in_high_q, in_low_q, in_close_q;
  logic                  in_end_q;

  // aggregation state
  logic [ohlc_pkg::COUNT_W-1:0] fill_count_q, fill_count_d;
  logic [PRICE_BITS-1:0]        held_open_q, held_open_d;
  logic [PRICE_BITS-1:0]        held_high_q, held_high_d;
  logic [PRICE_BITS-1:0]        held_low_q, held_low_d;
  logic [PRICE_BITS-1:0]        series_max_q, series_max_d;
  logic [PRICE_BITS-1:0]        series_min_q, series_min_d;
  logic                         series_started_q;

  // result register
  logic                  out_vld_q;
  logic [PRICE_BITS-1:0] bar_open_q, bar_high_q, bar_low_q, bar_close_q;
  logic [PRICE_BITS-1:0] ovr_high_q, ovr_low_q;
  logic                  final_q;

  ohlc_pkg::merge_ctl_t ctl;
  logic in_accept;
  logic advance;
  logic out_accept;

  ohlc_merge #(
    .PRICE_BITS (PRICE_BITS)
  ) u_merge (
    .price_open_i     (in_open_q),
    .price_high_i     (in_high_q),
    .price_low_i      (in_low_q),
    .series_end_i     (in_end_q),
    .group_size_i     (group_size_q),
    .fill_count_i     (fill_count_q),
    .held_open_i      (held_open_q),
    .held_high_i      (held_high_q),
    .held_low_i       (held_low_q),
    .series_max_i     (series_max_q),
    .series_min_i     (series_min_q),
    .series_started_i (series_started_q),
    .fill_count_o     (fill_count_d),
    .held_open_o      (held_open_d),
    .held_high_o      (held_high_d),
    .held_low_o       (held_low_d),
    .series_max_o     (series_max_d),
    .series_min_o     (series_min_d),
    .ctl_o            (ctl)
  );

  // A held candle moves on unless it closes a bar and the result slot is
  // occupied and stalled.
  assign out_accept = out_vld_q && !out_stall_i;
  assign advance    = in_vld_q && (!ctl.emit || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // control: config, valids, aggregation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q     <= ohlc_pkg::GROUP_DAILY;
      in_vld_q         <= 1'b0;
      out_vld_q        <= 1'b0;
      fill_count_q     <= '0;
      held_open_q      <= '0;
      held_high_q      <= '0;
      held_low_q       <= '0;
      series_max_q     <= '0;
      series_min_q     <= '0;
      series_started_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        group_size_q <= cfg_wr_data_i;
      end

      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end

      if (advance && ctl.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_accept) begin
        out_vld_q <= 1'b0;
      end

      if (advance) begin
        if (ctl.emit) begin
          // bar closes; a fresh bar starts on the next candle
          fill_count_q <= '0;
          held_open_q  <= '0;
          held_high_q  <= '0;
          held_low_q   <= '0;
        end else begin
          fill_count_q <= fill_count_d;
          held_open_q  <= held_open_d;
          held_high_q  <= held_high_d;
          held_low_q   <= held_low_d;
        end
        if (ctl.last) begin
          // end of series: extremes restart with the next candle
          series_max_q     <= '0;
          series_min_q     <= '0;
          series_started_q <= 1'b0;
        end else begin
          series_max_q     <= series_max_d;
          series_min_q     <= series_min_d;
          series_started_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_open_q  <= price_open_i;
      in_high_q  <= price_high_i;
      in_low_q   <= price_low_i;
      in_close_q <= price_close_i;
      in_end_q   <= series_end_i;
    end
    if (advance && ctl.emit) begin
      bar_open_q  <= held_open_d;
      bar_high_q  <= held_high_d;
      bar_low_q   <= held_low_d;
      bar_close_q <= in_close_q;
      ovr_high_q  <= series_max_d;
      ovr_low_q   <= series_min_d;
      final_q     <= ctl.last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign bar_open_o     = bar_open_q;
  assign bar_high_o     = bar_high_q;
  assign bar_low_o      = bar_low_q;
  assign bar_close_o    = bar_close_q;
  assign overall_high_o = ovr_high_q;
  assign overall_low_o  = ovr_low_q;
  assign final_bar_o    = final_q;

endmodule

/* test/ohlc_bar_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohlc_bar_checker
// Watches the candle and bar channels of the OHLC bar aggregator, keeps its
// own copy of the bar state, and compares every bar against the prediction.
// ----------------------------------------------------------------------------
module ohlc_bar_checker #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [ohlc_pkg::GROUP_W-1:0]  cfg_wr_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [PRICE_BITS-1:0]         price_open_i,
  input  logic [PRICE_BITS-1:0]         price_high_i,
  input  logic [PRICE_BITS-1:0]         price_low_i,
  input  logic [PRICE_BITS-1:0]         price_close_i,
  input  logic                          series_end_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [PRICE_BITS-1:0]         bar_open_i,
  input  logic [PRICE_BITS-1:0]         bar_high_i,
  input  logic [PRICE_BITS-1:0]         bar_low_i,
  input  logic [PRICE_BITS-1:0]         bar_close_i,
  input  logic [PRICE_BITS-1:0]         overall_high_i,
  input  logic [PRICE_BITS-1:0]         overall_low_i,
  input  logic                          final_bar_i,
  output int                            fail_count_o,
  output int                            bars_checked_o,
  output int                            final_bars_o,
  output int                            bars_pending_o
);

  typedef logic [PRICE_BITS-1:0] price_t;

  typedef struct packed {
    price_t open;
    price_t high;
    price_t low;
    price_t close;
    price_t run_high;
    price_t run_low;
    logic   last;
  } bar_t;

  bar_t                         expected_bars[$];
  logic [ohlc_pkg::GROUP_W-1:0] group_reg;
  logic [ohlc_pkg::COUNT_W-1:0] held_count;
  price_t                       held_open, held_high, held_low;
  price_t                       series_max, series_min;
  logic                         series_seen;

  // zero acts as one, anything past the maximum saturates
  function automatic int unsigned bar_length();
    if (group_reg == '0) return 1;
    if (group_reg > ohlc_pkg::GROUP_MAX) return ohlc_pkg::GROUP_MAX;
    return group_reg;
  endfunction

  // merges one candle; returns 1 with the finished bar when it closes one
  function automatic bit fold_candle(input price_t o, h, l, c, input logic last,
                                     output bar_t bar);
    int unsigned filled;
    if (h > series_max) series_max = h;
    if (!series_seen || l < series_min) series_min = l;
    series_seen = 1'b1;
    if (held_count == '0) begin
      held_open = o;
      held_high = h;
      held_low  = l;
    end else begin
      if (h > held_high) held_high = h;
      if (l < held_low) held_low = l;
    end
    filled = held_count + 1;
    bar = '0;
    if (filled < bar_length() && !last) begin
      held_count = filled[ohlc_pkg::COUNT_W-1:0];
      return 1'b0;
    end
    bar = '{open: held_open, high: held_high, low: held_low, close: c,
            run_high: series_max, run_low: series_min, last: last};
    held_count = '0;
    held_open  = '0;
    held_high  = '0;
    held_low   = '0;
    if (last) begin
      series_max  = '0;
      series_min  = '0;
      series_seen = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input price_t want, got);
    if (want !== got) begin
      $display("%0t: bar %0d mismatch on %s: expected %h, actual %h",
               $time, bars_checked_o, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    bar_t want, got;
    if (!rst_ni) begin
      expected_bars.delete();
      group_reg      = ohlc_pkg::GROUP_DAILY;
      held_count     = '0;
      held_open      = '0;
      held_high      = '0;
      held_low       = '0;
      series_max     = '0;
      series_min     = '0;
      series_seen    = 1'b0;
      fail_count_o   = 0;
      bars_checked_o = 0;
      final_bars_o   = 0;
    end else begin
      // bars leaving now come from candles accepted earlier: check first
      if (out_valid_i && !out_stall_i) begin
        got = '{open: bar_open_i, high: bar_high_i, low: bar_low_i,
                close: bar_close_i, run_high: overall_high_i,
                run_low: overall_low_i, last: final_bar_i};
        if (expected_bars.size() == 0) begin
          $display("%0t: unexpected bar, open %h high %h low %h close %h",
                   $time, got.open, got.high, got.low, got.close);
          fail_count_o++;
        end else begin
          want = expected_bars.pop_front();
          check_field("bar_open", want.open, got.open);
          check_field("bar_high", want.high, got.high);
          check_field("bar_low", want.low, got.low);
          check_field("bar_close", want.close, got.close);
          check_field("overall_high", want.run_high, got.run_high);
          check_field("overall_low", want.run_low, got.run_low);
          check_field("final_bar", price_t'(want.last), price_t'(got.last));
          bars_checked_o++;
          if (want.last) final_bars_o++;
        end
      end
      if (cfg_wr_en_i) group_reg = cfg_wr_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (fold_candle(price_open_i, price_high_i, price_low_i, price_close_i,
                        series_end_i, want))
          expected_bars.push_back(want);
      end
    end
    bars_pending_o = expected_bars.size();
  end

endmodule

/* test/tb_ohlc_bar_aggregator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ohlc_bar_aggregator_unit
// Candle stream regression for the OHLC bar aggregator.
// ----------------------------------------------------------------------------
// Drives directed candles (price extremes, series ends, partial bars, a group
// size lowered while a bar is half built) and then phases of random candles
// under a range of group sizes, zero and saturating values included. Both
// channels idle in random bursts; once, the bar side holds off long enough
// to back the block up. A separate checker predicts and compares every bar.
// ----------------------------------------------------------------------------
module tb_ohlc_bar_aggregator_unit;

  localparam int unsigned PRICE_BITS = 32;
  localparam int          WATCHDOG_LIMIT = 2000;  // cycles without a transaction
  localparam int          LONG_HOLD = 300;         // bar-side hold-off, in cycles
  localparam int          PHASES = 10;
  localparam int          PHASE_ITEMS = 100;

  typedef logic [PRICE_BITS-1:0] price_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_wr_en_i = 1'b0;
  logic [ohlc_pkg::GROUP_W-1:0] cfg_wr_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  price_t                       price_open_i = '0;
  price_t                       price_high_i = '0;
  price_t                       price_low_i = '0;
  price_t                       price_close_i = '0;
  logic                         series_end_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  price_t                       bar_open_o, bar_high_o, bar_low_o, bar_close_o;
  price_t                       overall_high_o, overall_low_o;
  logic                         final_bar_o;

  int fail_count, bars_checked, final_bars, bars_pending;
  int candles_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;        // no idling on either side
  bit hold_req = 1'b0;    // asks the bar side for one long hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ohlc_bar_aggregator_unit #(.PRICE_BITS(PRICE_BITS)) uut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .in_valid_i, .in_stall_o,
    .price_open_i, .price_high_i, .price_low_i, .price_close_i, .series_end_i,
    .out_valid_o, .out_stall_i,
    .bar_open_o, .bar_high_o, .bar_low_o, .bar_close_o,
    .overall_high_o, .overall_low_o, .final_bar_o
  );

  ohlc_bar_checker #(.PRICE_BITS(PRICE_BITS)) u_checker (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .price_open_i, .price_high_i, .price_low_i, .price_close_i, .series_end_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .bar_open_i(bar_open_o), .bar_high_i(bar_high_o), .bar_low_i(bar_low_o),
    .bar_close_i(bar_close_o), .overall_high_i(overall_high_o),
    .overall_low_i(overall_low_o), .final_bar_i(final_bar_o),
    .fail_count_o(fail_count), .bars_checked_o(bars_checked),
    .final_bars_o(final_bars), .bars_pending_o(bars_pending)
  );

  // Watchdog: any accepted transaction on either channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Bar side: random stall bursts, plus one long hold-off on
  // request so the held bar and result register fill and the candle channel
  // backs up while the sender keeps offering.
  initial begin : bar_sink
    int burst;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One candle transaction, optionally preceded by an idle burst. Valid stays
  // high between back-to-back candles; the payload holds while stalled.
  task automatic send_candle(input price_t o, h, l, c, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    price_open_i  <= o;
    price_high_i  <= h;
    price_low_i   <= l;
    price_close_i <= c;
    series_end_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    candles_sent++;
  endtask

  // Drop valid and wait until every predicted bar has come out.
  task automatic drain_bars();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (bars_pending != 0);
  endtask

  // Register writes only with the block idle; a candle closing no bar leaves
  // nothing to wait for, so let the input register empty before writing.
  task automatic write_group(input logic [ohlc_pkg::GROUP_W-1:0] value);
    drain_bars();
    repeat (4) @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [ohlc_pkg::GROUP_W-1:0] plan [PHASES];
    price_t v0, v1, v2, v3, mask, trend, o, h, l, c;
    price_t picks [3];
    logic last;
    int kind;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed ------------------------------------------------------
    // reset group size (daily): each candle is its own bar
    send_candle('0, '0, '0, '0, 1'b0);
    send_candle('1, '1, '1, '1, 1'b0);
    send_candle(32'hAAAA_AAAA, 32'hFFFF_0000, 32'h0000_FFFF, 32'h5555_5555, 1'b0);
    send_candle(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_8000, 1'b1);

    // weekly: one full bar, then a partial bar of two closed by series end;
    // the series low starts at the first low, not at zero
    write_group(ohlc_pkg::GROUP_WEEKLY);
    send_candle(32'h0064_0000, 32'h0066_0000, 32'h0063_0000, 32'h0065_0000, 1'b0);
    send_candle(32'h0065_0000, 32'h0068_8000, 32'h0064_0000, 32'h0068_0000, 1'b0);
    send_candle(32'h0068_0000, 32'h0069_0000, 32'h0061_4000, 32'h0062_0000, 1'b0);
    send_candle(32'h0062_0000, 32'h0063_0000, 32'h0060_0000, 32'h0060_8000, 1'b0);
    send_candle(32'h0060_8000, 32'h0064_0000, 32'h0060_0000, 32'h0063_0000, 1'b0);
    send_candle(32'h0063_0000, 32'h006A_0000, 32'h0062_0000, 32'h0069_0000, 1'b0);
    send_candle(32'h0069_0000, 32'h0069_8000, 32'h005F_0000, 32'h005F_8000, 1'b1);

    // group size zero behaves as daily
    write_group('0);
    send_candle(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_candle('1, '1, '0, '0, 1'b1);

    // monthly bar half built, then the size is lowered below the held count:
    // the next candle closes the bar
    write_group(ohlc_pkg::GROUP_MONTHLY);
    repeat (6) send_candle($urandom, $urandom, $urandom, $urandom, 1'b0);
    write_group(7'd3);
    send_candle(32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0200_0000, 1'b0);
    send_candle(32'h0300_0000, 32'h0400_0000, 32'h0000_0000, 32'h0350_0000, 1'b0);
    send_candle(32'h0350_0000, 32'h0360_0000, 32'h0340_0000, 32'h0345_0000, 1'b1);

    // --- random phases ------------------------------------------------
    plan = '{ohlc_pkg::GROUP_DAILY, ohlc_pkg::GROUP_WEEKLY, 7'd127,
             ohlc_pkg::GROUP_MONTHLY, 7'd0, 7'(ohlc_pkg::GROUP_MAX), 7'd65, 7'd2,
             7'($urandom_range(3, 63)), ohlc_pkg::GROUP_WEEKLY};
    trend = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      // the last phase runs with no idling at all
      if (p == PHASES - 1) calm = 1'b1;
      write_group(plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 30) hold_req = 1'b1;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          // noise: unrelated prices, high below low and the like
          o = $urandom; h = $urandom; l = $urandom; c = $urandom;
        end else if (kind == 1) begin
          // extremes mixed with random values
          picks = '{'0, '1, price_t'($urandom)};
          o = picks[$urandom_range(0, 2)];
          h = picks[$urandom_range(0, 2)];
          l = picks[$urandom_range(0, 2)];
          c = picks[$urandom_range(0, 2)];
        end else begin
          // well-formed candle around a drifting price, spread of random width
          mask = (price_t'(1) << $urandom_range(0, 24)) - 1;
          v0 = trend ^ ($urandom & mask);
          v1 = trend ^ ($urandom & mask);
          v2 = trend ^ ($urandom & mask);
          v3 = trend ^ ($urandom & mask);
          o = v0;
          c = v1;
          h = (v0 > v1) ? v0 : v1;
          if (v2 > h) h = v2;
          l = (v0 < v1) ? v0 : v1;
          if (v3 < l) l = v3;
          trend = c;
        end
        last = ($urandom_range(0, 39) == 0);
        send_candle(o, h, l, c, last);
        if (last) trend = $urandom;
      end
    end

    // --- wind down ----------------------------------------------------
    drain_bars();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d candles under %0d group settings.", candles_sent,
             settings_used);
    $display("Compared %0d bars, %0d of them closing a series.", bars_checked,
             final_bars);
    if (fail_count == 0 && bars_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ohlc_pkg.sv
rtl/ohlc_merge.sv
rtl/ohlc_bar_aggregator_unit.sv
test/ohlc_bar_checker.sv
test/tb_ohlc_bar_aggregator_unit.sv
